FILE: sv/srge_pkg.sv
// Shared types, register codes and star-graph helpers for the star recipe graph evaluator.
package srge_pkg;

    localparam int EDGE_LIM   = 55;
    localparam int NODE_LIM   = 11;
    localparam int POS_SLOTS  = 6;
    localparam int PADDR_W    = 4;

    typedef logic [1:0] reg_sel_t;
    localparam reg_sel_t REG_NODE_COUNT     = 2'd0;
    localparam reg_sel_t REG_STAR_COUNT     = 2'd1;
    localparam reg_sel_t REG_PUSH_POSITIONS = 2'd2;

    typedef struct packed {
        logic [3:0]  nodes;
        logic [3:0]  stars;
        logic [23:0] pos;
    } cfg_t;

    typedef struct packed {
        logic [3:0] top;
        logic [3:0] star_idx;
        logic [2:0] op_idx;
    } ctl_t;

    function automatic logic [EDGE_LIM-1:0] star_mask(input logic [3:0] k,
                                                      input logic [3:0] nodes);
        logic [EDGE_LIM-1:0] g;
        g = '0;
        for (int hi = 1; hi < NODE_LIM; hi++) begin
            for (int lo = 0; lo < hi; lo++) begin
                if (hi < int'(nodes) && (hi == int'(k) || lo == int'(k))) begin
                    g[hi*(hi-1)/2+lo] = 1'b1;
                end
            end
        end
        return g;
    endfunction

    function automatic logic [3:0] range_of(input int dig, input logic [3:0] nodes);
        logic [4:0] t;
        t = 5'(3 + dig);
        if (nodes <= 4'd3) begin
            return 4'd3;
        end
        if (t > {1'b0, nodes}) begin
            return nodes;
        end
        return t[3:0];
    endfunction

endpackage

FILE: sv/star_recipe_graph_evaluator.sv
// Top level of the star recipe graph evaluator: config registers, digit and slot pipelines.
//
//   channel   ports                          role
//   s_        s_valid s_ready s_op_mask      recipe operators and enumeration index
//             s_enum_index
//   m_        m_valid m_ready m_graph_bits   resulting edge bitset
//   apb       psel penable pwrite paddr      node_count, star_count, push_positions
//             pwdata prdata pready
//
// One beat enters per cycle while m_ is not stalled; the pipeline has 2*(MAX_STARS-2)
// digit stages (for MAX_STARS above 2) followed by 2*MAX_STARS-3 slot stages.
// Reset is synchronous on aresetn; it clears the stage valid bits and loads the
// register reset values, while stage data registers are left as they are.
// A stalled m_ beat freezes the whole pipeline; s_ready follows that enable.
module star_recipe_graph_evaluator import srge_pkg::*; #(
    parameter int MAX_NODES = 11,
    parameter int MAX_STARS = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [6:0]                             s_op_mask,
    input  logic [15:0]                            s_enum_index,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [MAX_NODES*(MAX_NODES-1)/2-1:0]   m_graph_bits,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [PADDR_W-1:0]                     paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int GW    = MAX_NODES * (MAX_NODES - 1) / 2;
    localparam int NDIG  = (MAX_STARS > 2) ? MAX_STARS - 2 : 1;
    localparam int ND2   = 2 * NDIG;
    localparam int NSLOT = 2 * MAX_STARS - 3;

    logic [3:0]  node_count_reg, node_count_next;
    logic [3:0]  star_count_reg, star_count_next;
    logic [23:0] push_positions_reg, push_positions_next;
    logic        wr_en;
    cfg_t        cfg;
    logic        en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        node_count_next     = node_count_reg;
        star_count_next     = star_count_reg;
        push_positions_next = push_positions_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                REG_NODE_COUNT:     node_count_next     = pwdata[3:0];
                REG_STAR_COUNT:     star_count_next     = pwdata[3:0];
                REG_PUSH_POSITIONS: push_positions_next = pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_NODE_COUNT:     prdata = {28'd0, node_count_reg};
            REG_STAR_COUNT:     prdata = {28'd0, star_count_reg};
            REG_PUSH_POSITIONS: prdata = {8'd0, push_positions_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg     <= 4'd11;
            star_count_reg     <= 4'd2;
            push_positions_reg <= 24'h765432;
        end else begin
            node_count_reg     <= node_count_next;
            star_count_reg     <= star_count_next;
            push_positions_reg <= push_positions_next;
        end
    end

    always_comb begin
        cfg.nodes = (node_count_reg > 4'(MAX_NODES)) ? 4'(MAX_NODES) : node_count_reg;
        if (star_count_reg > 4'(MAX_STARS)) begin
            cfg.stars = 4'(MAX_STARS);
        end else if (star_count_reg == 4'd0) begin
            cfg.stars = 4'd1;
        end else begin
            cfg.stars = star_count_reg;
        end
        cfg.pos = push_positions_reg;
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic                 dv_valid [0:ND2];
    logic [15:0]          dv_idx   [0:ND2];
    logic [3:0]           dv_rem   [0:ND2];
    logic [NDIG-1:0][3:0] dv_dig   [0:ND2];
    logic [6:0]           dv_op    [0:ND2];

    assign dv_valid[0] = s_valid;
    assign dv_idx[0]   = s_enum_index;
    assign dv_rem[0]   = 4'd0;
    assign dv_dig[0]   = '0;
    assign dv_op[0]    = s_op_mask;

    for (genvar g = 0; g < ND2; g++) begin : g_div
        srge_div_stage #(
            .NDIG (NDIG),
            .DIG  (g / 2),
            .HIGH ((g % 2) == 0)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .cfg       (cfg),
            .in_valid  (dv_valid[g]),
            .in_idx    (dv_idx[g]),
            .in_rem    (dv_rem[g]),
            .in_dig    (dv_dig[g]),
            .in_op     (dv_op[g]),
            .out_valid (dv_valid[g+1]),
            .out_idx   (dv_idx[g+1]),
            .out_rem   (dv_rem[g+1]),
            .out_dig   (dv_dig[g+1]),
            .out_op    (dv_op[g+1])
        );
    end

    logic                         sl_valid [0:NSLOT];
    logic [MAX_STARS-1:0][GW-1:0] sl_stk   [0:NSLOT];
    ctl_t                         sl_ctl   [0:NSLOT];
    logic [NDIG-1:0][3:0]         sl_dig   [0:NSLOT];
    logic [6:0]                   sl_op    [0:NSLOT];
    logic [EDGE_LIM-1:0]          star0_full, star1_full;

    assign star0_full = star_mask(4'd0, cfg.nodes);
    assign star1_full = star_mask(4'd1, cfg.nodes);

    always_comb begin
        sl_stk[0]    = '0;
        sl_stk[0][0] = star0_full[GW-1:0];
        sl_stk[0][1] = star1_full[GW-1:0];
        sl_ctl[0].top      = (cfg.stars == 4'd1) ? 4'd1 : 4'd2;
        sl_ctl[0].star_idx = 4'd2;
        sl_ctl[0].op_idx   = 3'd0;
    end

    assign sl_valid[0] = dv_valid[ND2];
    assign sl_dig[0]   = dv_dig[ND2];
    assign sl_op[0]    = dv_op[ND2];

    for (genvar g = 0; g < NSLOT; g++) begin : g_slot
        srge_slot_stage #(
            .MAX_STARS (MAX_STARS),
            .GW        (GW),
            .NDIG      (NDIG),
            .SLOT      (g + 2)
        ) u_slot (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .cfg       (cfg),
            .in_valid  (sl_valid[g]),
            .in_stk    (sl_stk[g]),
            .in_ctl    (sl_ctl[g]),
            .in_dig    (sl_dig[g]),
            .in_op     (sl_op[g]),
            .out_valid (sl_valid[g+1]),
            .out_stk   (sl_stk[g+1]),
            .out_ctl   (sl_ctl[g+1]),
            .out_dig   (sl_dig[g+1]),
            .out_op    (sl_op[g+1])
        );
    end

    assign m_valid      = sl_valid[NSLOT];
    assign m_graph_bits = sl_stk[NSLOT][0];

endmodule

FILE: sv/srge_div_stage.sv
// One half of a mixed-radix digit extraction: eight restoring division steps.
module srge_div_stage import srge_pkg::*; #(
    parameter int NDIG = 6,
    parameter int DIG  = 0,
    parameter bit HIGH = 1'b1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    input  logic [15:0]           in_idx,
    input  logic [3:0]            in_rem,
    input  logic [NDIG-1:0][3:0]  in_dig,
    input  logic [6:0]            in_op,
    output logic                  out_valid,
    output logic [15:0]           out_idx,
    output logic [3:0]            out_rem,
    output logic [NDIG-1:0][3:0]  out_dig,
    output logic [6:0]            out_op
);

    logic                 valid_reg;
    logic [15:0]          idx_reg, idx_next;
    logic [3:0]           rem_reg, rem_next;
    logic [NDIG-1:0][3:0] dig_reg, dig_next;
    logic [6:0]           op_reg;
    logic [3:0]           divisor;

    assign divisor = range_of(DIG, cfg.nodes);

    always_comb begin
        logic [4:0] t;
        logic [3:0] r;
        idx_next = in_idx;
        dig_next = in_dig;
        r = HIGH ? 4'd0 : in_rem;
        for (int b = 7; b >= 0; b--) begin
            t = {r, in_idx[HIGH ? 8 + b : b]};
            if (t >= {1'b0, divisor}) begin
                t = t - {1'b0, divisor};
                idx_next[HIGH ? 8 + b : b] = 1'b1;
            end else begin
                idx_next[HIGH ? 8 + b : b] = 1'b0;
            end
            r = t[3:0];
        end
        rem_next = r;
        if (!HIGH) begin
            dig_next[DIG] = r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_reg <= idx_next;
            rem_reg <= rem_next;
            dig_reg <= dig_next;
            op_reg  <= in_op;
        end
    end

    assign out_valid = valid_reg;
    assign out_idx   = idx_reg;
    assign out_rem   = rem_reg;
    assign out_dig   = dig_reg;
    assign out_op    = op_reg;

endmodule

FILE: sv/srge_slot_stage.sv
// One recipe slot: push an elementary star or merge the top two stack entries; inactive slots pass through.
module srge_slot_stage import srge_pkg::*; #(
    parameter int MAX_STARS = 8,
    parameter int GW        = 55,
    parameter int NDIG      = 6,
    parameter int SLOT      = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  cfg_t                            cfg,
    input  logic                            in_valid,
    input  logic [MAX_STARS-1:0][GW-1:0]    in_stk,
    input  ctl_t                            in_ctl,
    input  logic [NDIG-1:0][3:0]            in_dig,
    input  logic [6:0]                      in_op,
    output logic                            out_valid,
    output logic [MAX_STARS-1:0][GW-1:0]    out_stk,
    output ctl_t                            out_ctl,
    output logic [NDIG-1:0][3:0]            out_dig,
    output logic [6:0]                      out_op
);

    localparam logic [4:0] SLOT_ID = 5'(SLOT);

    logic                         valid_reg;
    logic [MAX_STARS-1:0][GW-1:0] stk_reg, stk_next;
    ctl_t                         ctl_reg, ctl_next;
    logic [NDIG-1:0][3:0]         dig_reg;
    logic [6:0]                   op_reg;
    logic [EDGE_LIM-1:0]          star_full;
    logic [3:0]                   rem;
    logic [3:0]                   at;
    logic [4:0]                   slots;
    logic                         active;
    logic                         push;
    logic                         inter;
    logic [7:0]                   op_ext;

    assign slots  = {cfg.stars, 1'b0} - 5'd1;
    assign active = SLOT_ID < slots;
    assign op_ext = {1'b0, in_op};
    assign inter  = op_ext[in_ctl.op_idx];

    always_comb begin
        at  = 4'd0;
        rem = 4'd0;
        for (int t = 0; t < POS_SLOTS; t++) begin
            if (in_ctl.star_idx == 4'(t + 2)) begin
                at = cfg.pos[4*t +: 4];
            end
        end
        for (int t = 0; t < NDIG; t++) begin
            if (in_ctl.star_idx == 4'(t + 2)) begin
                rem = in_dig[t];
            end
        end
    end

    assign push      = active && (in_ctl.star_idx < cfg.stars) && (at == SLOT_ID[3:0]);
    assign star_full = star_mask(rem, cfg.nodes);

    always_comb begin
        stk_next = in_stk;
        ctl_next = in_ctl;
        if (push) begin
            if (in_ctl.top < cfg.stars) begin
                for (int i = 0; i < MAX_STARS; i++) begin
                    if (in_ctl.top == 4'(i)) begin
                        stk_next[i] = star_full[GW-1:0];
                    end
                end
                ctl_next.top = in_ctl.top + 4'd1;
            end
            ctl_next.star_idx = in_ctl.star_idx + 4'd1;
        end else if (active) begin
            if (in_ctl.top > 4'd1 && in_ctl.top <= cfg.stars) begin
                for (int i = 0; i < MAX_STARS - 1; i++) begin
                    if (in_ctl.top == 4'(i + 2)) begin
                        stk_next[i] = inter ? (in_stk[i] & in_stk[i+1])
                                            : (in_stk[i] | in_stk[i+1]);
                    end
                end
                ctl_next.top = in_ctl.top - 4'd1;
            end
            if (in_ctl.op_idx != 3'd7) begin
                ctl_next.op_idx = in_ctl.op_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stk_reg <= stk_next;
            ctl_reg <= ctl_next;
            dig_reg <= in_dig;
            op_reg  <= in_op;
        end
    end

    assign out_valid = valid_reg;
    assign out_stk   = stk_reg;
    assign out_ctl   = ctl_reg;
    assign out_dig   = dig_reg;
    assign out_op    = op_reg;

`ifndef SYNTHESIS
    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (ctl_reg.top >= 4'd1 && ctl_reg.top <= 4'(MAX_STARS)))
        else $error("stack depth out of bounds");
    a_star_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (ctl_reg.star_idx >= 4'd2 && ctl_reg.star_idx <= 4'(MAX_STARS)))
        else $error("star counter out of bounds");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(valid_reg) && $stable(stk_reg)))
        else $error("stage changed while stalled");
`endif

endmodule
